### hw/rtl/spd_pkg.sv
// Shared types, codes and default sizes of the shortest-path engine.
// Used by every module of the block; depends on nothing.
`default_nettype none

package spd_pkg;

    localparam int NODE_FIELD_W = 10;
    localparam int WEIGHT_W     = 24;
    localparam int OUT_DIST_W   = 32;

    localparam int NODES_DEF      = 1024;
    localparam int EDGES_DEF      = 4096;
    localparam int HEAP_DEPTH_DEF = 4096;
    localparam int DIST_BITS_DEF  = 32;

    localparam logic [NODE_FIELD_W-1:0] SOURCE_RESET = 10'd1;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_ADD_EDGE = 2'd1,
        CMD_QUERY    = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_REACHED       = 2'd0,
        ST_UNREACHABLE   = 2'd1,
        ST_HEAP_OVERFLOW = 2'd2,
        ST_EDGES_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                    command;
        logic [NODE_FIELD_W-1:0] from_node;
        logic [NODE_FIELD_W-1:0] to_node;
        logic [WEIGHT_W-1:0]     edge_weight;
        logic [NODE_FIELD_W-1:0] target_node;
    } in_item_t;

    typedef struct packed {
        logic [OUT_DIST_W-1:0] distance;
        status_t               status;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE       = 5'd0,
        OP_LOAD       = 5'd1,
        OP_DECODE     = 5'd2,
        OP_SWEEP_HEAD = 5'd3,
        OP_SWEEP_BEST = 5'd4,
        OP_ADD_WR     = 5'd5,
        OP_POP_RD     = 5'd6,
        OP_POP_TAKE   = 5'd7,
        OP_SD_RD      = 5'd8,
        OP_SD_STEP    = 5'd9,
        OP_NODE_RD    = 5'd10,
        OP_CHECK      = 5'd11,
        OP_EDGE_RD    = 5'd12,
        OP_EDGE_TAKE  = 5'd13,
        OP_RELAX      = 5'd14,
        OP_SU_RD      = 5'd15,
        OP_SU_STEP    = 5'd16,
        OP_SU_PLACE   = 5'd17
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    emit;
        status_t code;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t command;
        logic sweep_last;
        logic add_oor;
        logic edges_full;
        logic query_oor;
        logic heap_empty;
        logic sd_done;
        logic stale;
        logic hit;
        logic edge_nil;
        logic improve;
        logic heap_full;
        logic su_root;
        logic su_go;
    } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/spd_ctrl.sv
// Controller state machine of the shortest-path engine.
// Depends on spd_pkg; drives spd_datapath through command and status structs.
`default_nettype none

module spd_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_accept,
    input  wire logic              out_free,
    input  wire spd_pkg::dp_stat_t stat,
    output logic                   in_ready,
    output spd_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [16:0] {
        S_CLR       = 17'h00001,
        S_IDLE      = 17'h00002,
        S_DECODE    = 17'h00004,
        S_ADD       = 17'h00008,
        S_SWEEP     = 17'h00010,
        S_POP       = 17'h00020,
        S_POP_TAKE  = 17'h00040,
        S_SD_RD     = 17'h00080,
        S_SD_STEP   = 17'h00100,
        S_NODE_RD   = 17'h00200,
        S_CHECK     = 17'h00400,
        S_EDGE      = 17'h00800,
        S_EDGE_TAKE = 17'h01000,
        S_RELAX     = 17'h02000,
        S_SU        = 17'h04000,
        S_SU_STEP   = 17'h08000,
        S_RESULT    = 17'h10000
    } state_t;

    state_t           state_reg, state_next;
    spd_pkg::status_t code_reg, code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            code_reg  <= spd_pkg::ST_UNREACHABLE;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        in_ready   = 1'b0;
        cmd.op     = spd_pkg::OP_NONE;
        cmd.emit   = 1'b0;
        cmd.code   = code_reg;
        case (state_reg)
            S_CLR: begin
                cmd.op = spd_pkg::OP_SWEEP_HEAD;
                if (stat.sweep_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_accept) begin
                    cmd.op     = spd_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.op = spd_pkg::OP_DECODE;
                case (stat.command)
                    spd_pkg::CMD_CLEAR: state_next = S_CLR;
                    spd_pkg::CMD_ADD_EDGE: begin
                        if (stat.add_oor) begin
                            state_next = S_IDLE;
                        end else if (stat.edges_full) begin
                            code_next  = spd_pkg::ST_EDGES_FULL;
                            state_next = S_RESULT;
                        end else begin
                            state_next = S_ADD;
                        end
                    end
                    spd_pkg::CMD_QUERY: begin
                        if (stat.query_oor) begin
                            code_next  = spd_pkg::ST_UNREACHABLE;
                            state_next = S_RESULT;
                        end else begin
                            state_next = S_SWEEP;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_ADD: begin
                cmd.op     = spd_pkg::OP_ADD_WR;
                state_next = S_IDLE;
            end
            S_SWEEP: begin
                cmd.op = spd_pkg::OP_SWEEP_BEST;
                if (stat.sweep_last) state_next = S_POP;
            end
            S_POP: begin
                if (stat.heap_empty) begin
                    code_next  = spd_pkg::ST_UNREACHABLE;
                    state_next = S_RESULT;
                end else begin
                    cmd.op     = spd_pkg::OP_POP_RD;
                    state_next = S_POP_TAKE;
                end
            end
            S_POP_TAKE: begin
                cmd.op     = spd_pkg::OP_POP_TAKE;
                state_next = S_SD_RD;
            end
            S_SD_RD: begin
                cmd.op     = spd_pkg::OP_SD_RD;
                state_next = S_SD_STEP;
            end
            S_SD_STEP: begin
                cmd.op     = spd_pkg::OP_SD_STEP;
                state_next = stat.sd_done ? S_NODE_RD : S_SD_RD;
            end
            S_NODE_RD: begin
                cmd.op     = spd_pkg::OP_NODE_RD;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                cmd.op = spd_pkg::OP_CHECK;
                if (stat.stale) begin
                    state_next = S_POP;
                end else if (stat.hit) begin
                    code_next  = spd_pkg::ST_REACHED;
                    state_next = S_RESULT;
                end else begin
                    state_next = S_EDGE;
                end
            end
            S_EDGE: begin
                if (stat.edge_nil) begin
                    state_next = S_POP;
                end else begin
                    cmd.op     = spd_pkg::OP_EDGE_RD;
                    state_next = S_EDGE_TAKE;
                end
            end
            S_EDGE_TAKE: begin
                cmd.op     = spd_pkg::OP_EDGE_TAKE;
                state_next = S_RELAX;
            end
            S_RELAX: begin
                cmd.op = spd_pkg::OP_RELAX;
                if (!stat.improve) begin
                    state_next = S_EDGE;
                end else if (stat.heap_full) begin
                    code_next  = spd_pkg::ST_HEAP_OVERFLOW;
                    state_next = S_RESULT;
                end else begin
                    state_next = S_SU;
                end
            end
            S_SU: begin
                if (stat.su_root) begin
                    cmd.op     = spd_pkg::OP_SU_PLACE;
                    state_next = S_EDGE;
                end else begin
                    cmd.op     = spd_pkg::OP_SU_RD;
                    state_next = S_SU_STEP;
                end
            end
            S_SU_STEP: begin
                cmd.op     = spd_pkg::OP_SU_STEP;
                state_next = stat.su_go ? S_SU : S_EDGE;
            end
            S_RESULT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLR;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/spd_datapath.sv
// Datapath of the shortest-path engine: graph, distance and heap memories,
// work registers and the compare/add logic. Depends on spd_pkg.
`default_nettype none

module spd_datapath #(
    parameter int NODES      = spd_pkg::NODES_DEF,
    parameter int EDGES      = spd_pkg::EDGES_DEF,
    parameter int HEAP_DEPTH = spd_pkg::HEAP_DEPTH_DEF,
    parameter int DIST_BITS  = spd_pkg::DIST_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire spd_pkg::ctrl_cmd_t                cmd,
    input  wire spd_pkg::in_item_t                 in_item,
    input  wire logic                              cfg_we,
    input  wire logic [spd_pkg::NODE_FIELD_W-1:0]  cfg_source,
    output spd_pkg::dp_stat_t                      stat,
    output spd_pkg::out_item_t                     result
);

    localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int EA     = (EDGES > 1) ? $clog2(EDGES) : 1;
    localparam int EW     = $clog2(EDGES + 1);
    localparam int HA     = $clog2(HEAP_DEPTH);
    localparam int HW     = $clog2(HEAP_DEPTH + 1);
    localparam int CW     = HA + 2;
    localparam int HE     = DIST_BITS + NODE_W;
    localparam int EDW    = NODE_W + spd_pkg::WEIGHT_W + EW;
    localparam int SW     = ((DIST_BITS > spd_pkg::WEIGHT_W) ? DIST_BITS
                             : spd_pkg::WEIGHT_W) + 1;

    localparam logic [DIST_BITS-1:0] INF = '1;

    logic [EW-1:0]        head_mem [NODES];
    logic [EDW-1:0]       edge_mem [EDGES];
    logic [DIST_BITS-1:0] best_mem [NODES];
    logic [HE-1:0]        heap_mem [HEAP_DEPTH];

    logic [spd_pkg::NODE_FIELD_W-1:0] src_reg;
    spd_pkg::in_item_t                item_reg;
    logic [NODE_W-1:0]                cnt_reg;
    logic [EW-1:0]                    ecount_reg;
    logic [HW-1:0]                    size_reg;
    logic [HA-1:0]                    idx_reg;
    logic [DIST_BITS-1:0]             cur_d_reg, nd_reg;
    logic [NODE_W-1:0]                cur_u_reg, v_reg;
    logic [EW-1:0]                    e_reg;
    logic [HE-1:0]                    mov_reg;

    logic [EW-1:0]        head_q;
    logic [EDW-1:0]       edge_q;
    logic [DIST_BITS-1:0] best_q;
    logic [HE-1:0]        heap_qa, heap_qb;

    logic [NODE_W-1:0]    head_ra, best_ra;
    logic [HA-1:0]        heap_raa, heap_rab;
    logic                 head_we, edge_we, best_we, heap_we;
    logic [NODE_W-1:0]    head_wa, best_wa;
    logic [EW-1:0]        head_wd;
    logic [DIST_BITS-1:0] best_wd;
    logic [HA-1:0]        heap_wa;
    logic [HE-1:0]        heap_wd;

    logic [NODE_W-1:0]          e_dest;
    logic [spd_pkg::WEIGHT_W-1:0] e_cost;
    logic [EW-1:0]              e_link;
    logic [SW-1:0]              sum;
    logic [DIST_BITS-1:0]       nd_sat;
    logic [CW-1:0]              l_idx, r_idx;
    logic                       l_ok, r_ok, pick_l, pick_r;
    logic [HE-1:0]              best_child;
    logic [HA-1:0]              parent_idx;
    logic [63:0]                d_wide;

    function automatic logic ahead(input logic [HE-1:0] a, input logic [HE-1:0] b);
        logic [DIST_BITS-1:0] da, db;
        da = a[HE-1 -: DIST_BITS];
        db = b[HE-1 -: DIST_BITS];
        return (da < db) || ((da == db) && (a[NODE_W-1:0] > b[NODE_W-1:0]));
    endfunction

    assign e_dest = edge_q[EDW-1 -: NODE_W];
    assign e_cost = edge_q[EW +: spd_pkg::WEIGHT_W];
    assign e_link = edge_q[EW-1:0];

    assign sum    = SW'(cur_d_reg) + SW'(e_cost);
    assign nd_sat = (sum > SW'(INF)) ? INF : sum[DIST_BITS-1:0];

    assign l_idx      = CW'({idx_reg, 1'b1});
    assign r_idx      = l_idx + CW'(1);
    assign l_ok       = l_idx < CW'(size_reg);
    assign r_ok       = r_idx < CW'(size_reg);
    assign pick_l     = l_ok && ahead(heap_qa, mov_reg);
    assign best_child = pick_l ? heap_qa : mov_reg;
    assign pick_r     = r_ok && ahead(heap_qb, best_child);
    assign parent_idx = HA'((idx_reg - HA'(1)) >> 1);

    // status toward the controller
    always_comb begin
        stat.command    = item_reg.command;
        stat.sweep_last = cnt_reg == NODE_W'(NODES - 1);
        stat.add_oor    = (32'(item_reg.from_node) >= NODES)
                       || (32'(item_reg.to_node) >= NODES);
        stat.edges_full = ecount_reg >= EW'(EDGES);
        stat.query_oor  = (32'(src_reg) >= NODES)
                       || (32'(item_reg.target_node) >= NODES);
        stat.heap_empty = size_reg == '0;
        stat.sd_done    = !pick_l && !pick_r;
        stat.stale      = cur_d_reg > best_q;
        stat.hit        = 32'(cur_u_reg) == 32'(item_reg.target_node);
        stat.edge_nil   = e_reg >= EW'(EDGES);
        stat.improve    = nd_reg < best_q;
        stat.heap_full  = size_reg >= HW'(HEAP_DEPTH);
        stat.su_root    = idx_reg == '0;
        stat.su_go      = ahead(mov_reg, heap_qa);
    end

    assign d_wide          = 64'(cur_d_reg);
    assign result.status   = cmd.code;
    assign result.distance = (cmd.code == spd_pkg::ST_REACHED && d_wide[63:32] == '0)
                           ? d_wide[31:0] : '1;

    // memory port selection
    always_comb begin
        head_ra  = (cmd.op == spd_pkg::OP_NODE_RD) ? cur_u_reg
                                                   : NODE_W'(item_reg.from_node);
        best_ra  = (cmd.op == spd_pkg::OP_NODE_RD) ? cur_u_reg : e_dest;
        heap_raa = '0;
        heap_rab = HA'(size_reg - HW'(1));
        case (cmd.op)
            spd_pkg::OP_SD_RD: begin
                heap_raa = HA'(l_idx);
                heap_rab = HA'(r_idx);
            end
            spd_pkg::OP_SU_RD: heap_raa = parent_idx;
            default: ;
        endcase

        head_we = 1'b0;
        head_wa = cnt_reg;
        head_wd = EW'(EDGES);
        edge_we = cmd.op == spd_pkg::OP_ADD_WR;
        best_we = 1'b0;
        best_wa = cnt_reg;
        best_wd = (32'(cnt_reg) == 32'(src_reg)) ? '0 : INF;
        heap_we = 1'b0;
        heap_wa = idx_reg;
        heap_wd = mov_reg;
        case (cmd.op)
            spd_pkg::OP_SWEEP_HEAD: head_we = 1'b1;
            spd_pkg::OP_ADD_WR: begin
                head_we = 1'b1;
                head_wa = NODE_W'(item_reg.from_node);
                head_wd = ecount_reg;
            end
            spd_pkg::OP_SWEEP_BEST: begin
                best_we = 1'b1;
                heap_we = 1'b1;
                heap_wa = '0;
                heap_wd = {{DIST_BITS{1'b0}}, NODE_W'(src_reg)};
            end
            spd_pkg::OP_RELAX: begin
                best_we = stat.improve;
                best_wa = v_reg;
                best_wd = nd_reg;
            end
            spd_pkg::OP_SD_STEP: begin
                heap_we = 1'b1;
                heap_wd = pick_r ? heap_qb : best_child;
            end
            spd_pkg::OP_SU_PLACE: heap_we = 1'b1;
            spd_pkg::OP_SU_STEP: begin
                heap_we = 1'b1;
                heap_wd = stat.su_go ? heap_qa : mov_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        head_q <= head_mem[head_ra];
    end

    always_ff @(posedge aclk) begin
        if (edge_we) begin
            edge_mem[EA'(ecount_reg)] <= {NODE_W'(item_reg.to_node),
                                          item_reg.edge_weight, head_q};
        end
        edge_q <= edge_mem[EA'(e_reg)];
    end

    always_ff @(posedge aclk) begin
        if (best_we) best_mem[best_wa] <= best_wd;
        best_q <= best_mem[best_ra];
    end

    always_ff @(posedge aclk) begin
        if (heap_we) heap_mem[heap_wa] <= heap_wd;
        heap_qa <= heap_mem[heap_raa];
        heap_qb <= heap_mem[heap_rab];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg    <= spd_pkg::SOURCE_RESET;
            cnt_reg    <= '0;
            ecount_reg <= '0;
            size_reg   <= '0;
        end else begin
            if (cfg_we) src_reg <= cfg_source;
            case (cmd.op)
                spd_pkg::OP_LOAD: cnt_reg <= '0;
                spd_pkg::OP_SWEEP_HEAD: begin
                    cnt_reg    <= cnt_reg + NODE_W'(1);
                    ecount_reg <= '0;
                end
                spd_pkg::OP_SWEEP_BEST: begin
                    cnt_reg  <= cnt_reg + NODE_W'(1);
                    size_reg <= HW'(1);
                end
                spd_pkg::OP_ADD_WR: ecount_reg <= ecount_reg + EW'(1);
                spd_pkg::OP_POP_TAKE: size_reg <= size_reg - HW'(1);
                spd_pkg::OP_RELAX: begin
                    if (stat.improve && !stat.heap_full) size_reg <= size_reg + HW'(1);
                end
                default: ;
            endcase
        end
    end

    // work registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            spd_pkg::OP_LOAD: item_reg <= in_item;
            spd_pkg::OP_POP_TAKE: begin
                cur_d_reg <= heap_qa[HE-1 -: DIST_BITS];
                cur_u_reg <= heap_qa[NODE_W-1:0];
                mov_reg   <= heap_qb;
                idx_reg   <= '0;
            end
            spd_pkg::OP_SD_STEP: begin
                if (pick_r) idx_reg <= HA'(r_idx);
                else if (pick_l) idx_reg <= HA'(l_idx);
            end
            spd_pkg::OP_CHECK: e_reg <= head_q;
            spd_pkg::OP_EDGE_TAKE: begin
                v_reg  <= e_dest;
                nd_reg <= nd_sat;
                e_reg  <= e_link;
            end
            spd_pkg::OP_RELAX: begin
                idx_reg <= HA'(size_reg);
                mov_reg <= {nd_reg, v_reg};
            end
            spd_pkg::OP_SU_STEP: begin
                if (stat.su_go) idx_reg <= parent_idx;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/shortest_path_dijkstra_core.sv
// Top level of the shortest-path engine: request channels, output register,
// controller and datapath. Depends on spd_pkg, spd_ctrl, spd_datapath.
//
//  channel | direction | handshake           | payload
//  s_      | in        | s_valid / s_ready   | s_item (command, nodes, weight, target)
//  m_      | out       | m_valid / m_ready   | m_item (distance, status)
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_data (source node)
//
// After reset the adjacency heads are cleared in a pass over all nodes; s_ready is low.
// Add edge is decoded, then writes the edge and its list head; clear graph repeats
// the head pass. A query first resets the distances in a pass over all nodes, then per
// pop takes the heap top and sifts the last entry down, and per edge reads it, relaxes
// it and sifts the new entry up; all memories are read through registers.
// A result waits in the output register while the next request is accepted.
`default_nettype none

module shortest_path_dijkstra_core #(
    parameter int NODES      = spd_pkg::NODES_DEF,
    parameter int EDGES      = spd_pkg::EDGES_DEF,
    parameter int HEAP_DEPTH = spd_pkg::HEAP_DEPTH_DEF,
    parameter int DIST_BITS  = spd_pkg::DIST_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire spd_pkg::in_item_t                s_item,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output spd_pkg::out_item_t                    m_item,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [spd_pkg::NODE_FIELD_W-1:0] cfg_data
);

    spd_pkg::ctrl_cmd_t cmd;
    spd_pkg::dp_stat_t  stat;
    spd_pkg::out_item_t result;
    logic               in_ready, out_free;
    logic               m_valid_reg;
    spd_pkg::out_item_t m_item_reg;

    assign s_ready   = in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    spd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_valid && in_ready),
        .out_free  (out_free),
        .stat      (stat),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    spd_datapath #(
        .NODES      (NODES),
        .EDGES      (EDGES),
        .HEAP_DEPTH (HEAP_DEPTH),
        .DIST_BITS  (DIST_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_item    (s_item),
        .cfg_we     (cfg_valid),
        .cfg_source (cfg_data),
        .stat       (stat),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) m_item_reg <= result;
    end

endmodule

`default_nettype wire

### hw/rtl/spd_checker.sv
// Port-level checks of the shortest-path engine, bound to the top level.
// Depends on spd_pkg and shortest_path_dijkstra_core.
`default_nettype none

module spd_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire spd_pkg::out_item_t m_item
);

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result dropped or changed while stalled");

    a_clear_after_reset: assert property (@(posedge aclk)
        !$past(aresetn) && aresetn |-> !s_ready)
        else $error("request taken during clearing pass");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while first is decoded");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared without decode");

endmodule

bind shortest_path_dijkstra_core spd_checker u_spd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire

### sim/shortest_path_dijkstra_core_tb.sv
// Testbench for shortest_path_dijkstra_core: drives clear, add-edge, query and no-op
// requests and source writes, predicts query results with its own heap-based search,
// checks every result. Depends on spd_pkg and shortest_path_dijkstra_core.
`timescale 1ns / 100ps

module shortest_path_dijkstra_core_tb;

    localparam int NODES      = spd_pkg::NODES_DEF;
    localparam int EDGES      = spd_pkg::EDGES_DEF;
    localparam int HEAP_DEPTH = spd_pkg::HEAP_DEPTH_DEF;
    localparam int NFW        = spd_pkg::NODE_FIELD_W;
    localparam int WW         = spd_pkg::WEIGHT_W;
    localparam longint unsigned DIST_INF = 64'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int unsigned W_MAX = (1 << WW) - 1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    spd_pkg::in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    spd_pkg::out_item_t m_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [NFW-1:0] cfg_data = '0;

    shortest_path_dijkstra_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // graph mirror and search state
    int unsigned src_node;
    int unsigned adj_head [NODES];
    int unsigned edge_to [EDGES];
    int unsigned edge_w [EDGES];
    int unsigned edge_next [EDGES];
    int unsigned edge_total;
    longint unsigned dist_best [NODES];
    longint unsigned heap_dist [HEAP_DEPTH];
    int unsigned heap_node [HEAP_DEPTH];
    int unsigned heap_len;

    spd_pkg::out_item_t pending_results [$];
    int errors = 0;
    int requests_sent = 0;
    int queries_sent = 0;
    int results_seen = 0;
    int reached_seen = 0;
    int cfg_writes = 0;
    longint cycles = 0;
    bit calm = 1'b0;

    function automatic bit heap_ahead(int unsigned a, int unsigned b);
        if (heap_dist[a] != heap_dist[b])
            return heap_dist[a] < heap_dist[b];
        return heap_node[a] > heap_node[b];
    endfunction

    function automatic void heap_swap(int unsigned a, int unsigned b);
        longint unsigned d;
        int unsigned n;
        d = heap_dist[a]; n = heap_node[a];
        heap_dist[a] = heap_dist[b]; heap_node[a] = heap_node[b];
        heap_dist[b] = d; heap_node[b] = n;
    endfunction

    function automatic bit heap_insert(longint unsigned d, int unsigned n);
        int unsigned i;
        int unsigned p;
        if (heap_len >= HEAP_DEPTH)
            return 1'b0;
        i = heap_len;
        heap_len++;
        heap_dist[i] = d;
        heap_node[i] = n;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!heap_ahead(i, p))
                break;
            heap_swap(i, p);
            i = p;
        end
        return 1'b1;
    endfunction

    function automatic void heap_take(output longint unsigned d, output int unsigned n);
        int unsigned i;
        int unsigned l;
        int unsigned m;
        d = heap_dist[0];
        n = heap_node[0];
        heap_len--;
        heap_dist[0] = heap_dist[heap_len];
        heap_node[0] = heap_node[heap_len];
        i = 0;
        forever begin
            l = 2 * i + 1;
            m = i;
            if (l < heap_len && heap_ahead(l, m))
                m = l;
            if (l + 1 < heap_len && heap_ahead(l + 1, m))
                m = l + 1;
            if (m == i)
                break;
            heap_swap(i, m);
            i = m;
        end
    endfunction

    function automatic spd_pkg::out_item_t shortest_distance(int unsigned target);
        spd_pkg::out_item_t r;
        longint unsigned d;
        longint unsigned nd;
        int unsigned u;
        int unsigned e;
        int unsigned v;
        r.distance = '1;
        r.status = spd_pkg::ST_UNREACHABLE;
        if (src_node >= NODES || target >= NODES)
            return r;
        for (int i = 0; i < NODES; i++)
            dist_best[i] = DIST_INF;
        dist_best[src_node] = 0;
        heap_len = 0;
        void'(heap_insert(0, src_node));
        while (heap_len > 0) begin
            heap_take(d, u);
            if (d > dist_best[u])
                continue;
            if (u == target) begin
                r.distance = d[31:0];
                r.status = spd_pkg::ST_REACHED;
                return r;
            end
            e = adj_head[u];
            while (e < EDGES) begin
                v = edge_to[e];
                nd = d + edge_w[e];
                if (nd > DIST_INF)
                    nd = DIST_INF;
                if (nd < dist_best[v]) begin
                    dist_best[v] = nd;
                    if (!heap_insert(nd, v)) begin
                        r.status = spd_pkg::ST_HEAP_OVERFLOW;
                        return r;
                    end
                end
                e = edge_next[e];
            end
        end
        return r;
    endfunction

    function automatic void clear_adjacency();
        for (int i = 0; i < NODES; i++)
            adj_head[i] = EDGES;
        edge_total = 0;
    endfunction

    function automatic void apply_request(spd_pkg::in_item_t it);
        spd_pkg::out_item_t r;
        case (it.command)
            spd_pkg::CMD_CLEAR: clear_adjacency();
            spd_pkg::CMD_ADD_EDGE: begin
                if (32'(it.from_node) < NODES && 32'(it.to_node) < NODES) begin
                    if (edge_total >= EDGES) begin
                        r.distance = '1;
                        r.status = spd_pkg::ST_EDGES_FULL;
                        pending_results = {pending_results, r};
                    end else begin
                        edge_to[edge_total] = 32'(it.to_node);
                        edge_w[edge_total] = 32'(it.edge_weight);
                        edge_next[edge_total] = adj_head[it.from_node];
                        adj_head[it.from_node] = edge_total;
                        edge_total++;
                    end
                end
            end
            spd_pkg::CMD_QUERY: begin
                queries_sent++;
                r = shortest_distance(32'(it.target_node));
                pending_results = {pending_results, r};
            end
            default: ;
        endcase
    endfunction

    task automatic send_request(spd_pkg::in_item_t it);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        apply_request(it);
    endtask

    function automatic spd_pkg::in_item_t make_request(spd_pkg::cmd_t c, int unsigned a,
                                                       int unsigned b, int unsigned w,
                                                       int unsigned t);
        spd_pkg::in_item_t it;
        it.command = c;
        it.from_node = NFW'(a);
        it.to_node = NFW'(b);
        it.edge_weight = WW'(w);
        it.target_node = NFW'(t);
        return it;
    endfunction

    task automatic add_edge(int unsigned a, int unsigned b, int unsigned w);
        send_request(make_request(spd_pkg::CMD_ADD_EDGE, a, b, w, $urandom));
    endtask

    task automatic query(int unsigned t);
        send_request(make_request(spd_pkg::CMD_QUERY, $urandom, $urandom, $urandom, t));
    endtask

    task automatic clear_graph();
        send_request(make_request(spd_pkg::CMD_CLEAR, $urandom, $urandom, $urandom,
                                  $urandom));
    endtask

    // hold off until every result is back and the block has gone quiet
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (NODES + 40) @(posedge aclk);
    endtask

    task automatic write_source(int unsigned n);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= NFW'(n);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        src_node = n;
        cfg_writes++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result distance=%0h status=%0d",
                       m_item.distance, m_item.status);
                errors++;
            end else begin
                if (m_item.distance !== pending_results[0].distance) begin
                    $error("distance expected %0h actual %0h",
                           pending_results[0].distance, m_item.distance);
                    errors++;
                end
                if (m_item.status !== pending_results[0].status) begin
                    $error("status expected %0d actual %0d",
                           pending_results[0].status, m_item.status);
                    errors++;
                end
                if (pending_results[0].status == spd_pkg::ST_REACHED)
                    reached_seen++;
                void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    task automatic test_reset_source();
        query(1);
        query(5);
        add_edge(1, 5, 7);
        add_edge(1, 5, 3);
        query(5);
    endtask

    task automatic test_directed();
        clear_graph();
        add_edge(1, 2, 0);
        add_edge(2, 3, W_MAX);
        add_edge(1, 3, W_MAX);
        add_edge(3, 3, 9);
        add_edge(2, 1023, 1);
        add_edge(1023, 0, W_MAX);
        add_edge(3, 4, 20);
        add_edge(2, 4, 30);
        send_request(make_request(spd_pkg::CMD_NONE, 1023, 1023, W_MAX, 1023));
        send_request(make_request(spd_pkg::CMD_NONE, 0, 0, 0, 0));
        query(3);
        query(1023);
        query(0);
        query(4);
        query(6);
        query(1);
    endtask

    task automatic test_saturation();
        write_source(0);
        clear_graph();
        for (int i = 0; i < 257; i++)
            add_edge(i, i + 1, W_MAX);
        query(256);
        query(257);
        query(0);
    endtask

    task automatic test_source_extremes();
        write_source(1023);
        clear_graph();
        add_edge(1023, 0, 4);
        add_edge(0, 1023, 4);
        query(0);
        query(1023);
        write_source(0);
        query(1023);
        query(0);
    endtask

    function automatic int unsigned pick_node();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 31);
        return $urandom_range(0, NODES - 1);
    endfunction

    task automatic test_random();
        int unsigned roll;
        int unsigned w;
        for (int ph = 0; ph < 25; ph++) begin
            if (ph >= 21)
                calm = 1'b1;
            if (ph % 3 == 0) begin
                case ($urandom_range(0, 4))
                    0: write_source(0);
                    1: write_source(NODES - 1);
                    2: write_source($urandom_range(0, NODES - 1));
                    default: write_source($urandom_range(0, 31));
                endcase
            end
            if ($urandom_range(0, 1) == 0)
                clear_graph();
            for (int k = 0; k < 60; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 84) begin
                    case ($urandom_range(0, 3))
                        0: w = $urandom_range(0, 3);
                        1: w = $urandom;
                        2: w = W_MAX - $urandom_range(0, 3);
                        default: w = $urandom_range(0, 1000);
                    endcase
                    add_edge(pick_node(), pick_node(), w);
                end else if (roll < 96) begin
                    query(pick_node());
                end else if (roll < 98) begin
                    send_request(make_request(spd_pkg::CMD_NONE, $urandom, $urandom,
                                              $urandom, $urandom));
                end else begin
                    clear_graph();
                end
            end
        end
    endtask

    initial begin
        src_node = 32'(spd_pkg::SOURCE_RESET);
        clear_adjacency();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_source();
        test_directed();
        test_saturation();
        test_source_extremes();
        test_random();
        drain();
        $display("Sent %0d requests (%0d queries), %0d source writes.",
                 requests_sent, queries_sent, cfg_writes);
        $display("Checked %0d results, %0d of them reached paths.", results_seen, reached_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
